>>> hw/rtl/crs_pkg.sv
package crs_pkg;

  localparam int ROWS = 16;
  localparam int COLS = 8;
  localparam int ROW_W = 4;
  localparam int COL_W = 3;
  localparam int MASK_W = 8;

  localparam logic [MASK_W-1:0] COL_MASK = MASK_W'((9'd1 << COLS) - 9'd1);

  localparam logic [1:0] REQ_SWITCH  = 2'd0;
  localparam logic [1:0] REQ_RESET   = 2'd1;
  localparam logic [1:0] REQ_SAVE    = 2'd2;
  localparam logic [1:0] REQ_RESTORE = 2'd3;

  typedef struct packed {
    logic load_switch;
    logic clear_map;
    logic save_map;
    logic scan_start;
    logic scan_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_hit;
    logic scan_last_row;
  } status_t;

endpackage

>>> hw/rtl/crs_ctrl.sv
module crs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       req_type,
  input  crs_pkg::status_t status,
  output crs_pkg::cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_stall = !((state == ST_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type)
            crs_pkg::REQ_SWITCH:  cmd.load_switch = 1'b1;
            crs_pkg::REQ_RESET:   cmd.clear_map = 1'b1;
            crs_pkg::REQ_SAVE:    cmd.save_map = 1'b1;
            crs_pkg::REQ_RESTORE: begin
              cmd.scan_start = 1'b1;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // hold on a differing row until the output register frees up
        if (!status.scan_hit || status.out_free) begin
          cmd.scan_step = 1'b1;
          if (status.scan_last_row) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_restore_enters_scan: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == crs_pkg::REQ_RESTORE) |=> state == ST_SCAN)
    else $error("restore did not start a scan");

  a_no_step_into_busy_output: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step && status.scan_hit |-> status.out_free)
    else $error("scan emitted into a full output register");

endmodule

>>> hw/rtl/crs_datapath.sv
module crs_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  crs_pkg::cmd_t               cmd,
  output crs_pkg::status_t            status,
  input  logic [crs_pkg::ROW_W-1:0]   sel_row,
  input  logic [crs_pkg::COL_W-1:0]   sel_column,
  input  logic                        turn_on,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        chip_reset,
  output logic [crs_pkg::ROW_W-1:0]   cmd_row,
  output logic [crs_pkg::MASK_W-1:0]  on_mask,
  output logic [crs_pkg::MASK_W-1:0]  off_mask,
  output logic                        last
);

  logic [crs_pkg::MASK_W-1:0] live_map  [crs_pkg::ROWS];
  logic [crs_pkg::MASK_W-1:0] saved_map [crs_pkg::ROWS];
  logic [crs_pkg::MASK_W-1:0] row_diff  [crs_pkg::ROWS];
  logic [crs_pkg::ROWS-1:0]   hit_vec;
  logic [crs_pkg::ROW_W-1:0]  idx;
  logic                       later_hit;
  logic                       sel_inside;
  logic [crs_pkg::MASK_W-1:0] sel_bit;
  logic [crs_pkg::MASK_W-1:0] cur_diff;
  logic [crs_pkg::MASK_W-1:0] cur_saved;
  logic                       emit_scan;
  logic                       load;

  always_comb begin
    later_hit = 1'b0;
    for (int r = 0; r < crs_pkg::ROWS; r++) begin
      row_diff[r] = (saved_map[r] ^ live_map[r]) & crs_pkg::COL_MASK;
      hit_vec[r]  = |row_diff[r];
      if (hit_vec[r] && ({1'b0, idx} < 5'(r))) begin
        later_hit = 1'b1;
      end
    end
  end

  assign cur_diff   = row_diff[idx];
  assign cur_saved  = saved_map[idx];
  assign sel_inside = ({1'b0, sel_row} < 5'(crs_pkg::ROWS)) &&
                      ({1'b0, sel_column} < 4'(crs_pkg::COLS));
  assign sel_bit    = crs_pkg::MASK_W'(1) << sel_column;
  assign emit_scan  = cmd.scan_step && hit_vec[idx];
  assign load       = cmd.load_switch || cmd.clear_map || emit_scan;

  assign status.out_free      = !out_valid || !out_stall;
  assign status.scan_hit      = hit_vec[idx];
  assign status.scan_last_row = (idx == crs_pkg::ROW_W'(crs_pkg::ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_step && !status.scan_last_row) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < crs_pkg::ROWS; r++) begin
        live_map[r]  <= '0;
        saved_map[r] <= '0;
      end
    end else begin
      if (cmd.clear_map) begin
        for (int r = 0; r < crs_pkg::ROWS; r++) begin
          live_map[r] <= '0;
        end
      end else if (cmd.load_switch && sel_inside) begin
        if (turn_on) begin
          live_map[sel_row] <= live_map[sel_row] | sel_bit;
        end else begin
          live_map[sel_row] <= live_map[sel_row] & ~sel_bit;
        end
      end else if (emit_scan) begin
        live_map[idx] <= live_map[idx] ^ cur_diff;
      end
      if (cmd.save_map) begin
        for (int r = 0; r < crs_pkg::ROWS; r++) begin
          saved_map[r] <= live_map[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      priority if (cmd.clear_map) begin
        chip_reset <= 1'b1;
        cmd_row    <= '0;
        on_mask    <= '0;
        off_mask   <= '0;
        last       <= 1'b1;
      end else if (cmd.load_switch) begin
        chip_reset <= 1'b0;
        cmd_row    <= sel_row;
        on_mask    <= turn_on ? sel_bit : '0;
        off_mask   <= turn_on ? '0 : sel_bit;
        last       <= 1'b1;
      end else begin
        chip_reset <= 1'b0;
        cmd_row    <= idx;
        on_mask    <= cur_saved & cur_diff;
        off_mask   <= ~cur_saved & cur_diff;
        last       <= !later_hit;
      end
    end
  end

  a_reset_cmd_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && chip_reset |-> on_mask == '0 && off_mask == '0 && last)
    else $error("chip reset command carries masks");

  a_masks_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (on_mask & off_mask) == '0)
    else $error("on and off masks overlap");

endmodule

>>> hw/rtl/crosspoint_shadow_restore_unit.sv
// Shadow controller for a 16 x 8 crosspoint switch.
// Input channel (in_valid / in_stall) carries one request: req_type with
// sel_row, sel_column and turn_on for a switch request. Output channel
// (out_valid / out_stall) carries one command per beat: chip_reset, cmd_row,
// on_mask, off_mask and last, which marks the final command of a request.
// Switch and chip-reset requests give one command, registered in the cycle
// after acceptance. A save request gives no command. A restore request
// walks the rows in ascending order, one row per cycle except while a
// differing row waits on a stalled output; each differing row gives one
// command. The next request can be taken once the row walk in the datapath
// ends. in_stall stays high while a restore runs and while the output
// register holds a command that is being stalled. A stalled command holds
// its value until taken.
// Reset clears the live map and the snapshot and drops out_valid.
module crosspoint_shadow_restore_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [crs_pkg::ROW_W-1:0]   sel_row,
  input  logic [crs_pkg::COL_W-1:0]   sel_column,
  input  logic                        turn_on,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        chip_reset,
  output logic [crs_pkg::ROW_W-1:0]   cmd_row,
  output logic [crs_pkg::MASK_W-1:0]  on_mask,
  output logic [crs_pkg::MASK_W-1:0]  off_mask,
  output logic                        last
);

  crs_pkg::cmd_t    cmd;
  crs_pkg::status_t status;

  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  crs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sel_row    (sel_row),
    .sel_column (sel_column),
    .turn_on    (turn_on),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .chip_reset (chip_reset),
    .cmd_row    (cmd_row),
    .on_mask    (on_mask),
    .off_mask   (off_mask),
    .last       (last)
  );

endmodule

>>> tb/crosspoint_cmd_checker.sv
`timescale 1ns / 1ps

module crosspoint_cmd_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [crs_pkg::ROW_W-1:0]   sel_row,
  input  logic [crs_pkg::COL_W-1:0]   sel_column,
  input  logic                        turn_on,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        chip_reset,
  input  logic [crs_pkg::ROW_W-1:0]   cmd_row,
  input  logic [crs_pkg::MASK_W-1:0]  on_mask,
  input  logic [crs_pkg::MASK_W-1:0]  off_mask,
  input  logic                        last,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic                       chip_reset;
    logic [crs_pkg::ROW_W-1:0]  row;
    logic [crs_pkg::MASK_W-1:0] on_mask;
    logic [crs_pkg::MASK_W-1:0] off_mask;
    logic                       last;
  } switch_cmd_t;

  switch_cmd_t                pending_cmds[$];
  logic [crs_pkg::MASK_W-1:0] shadow_live [crs_pkg::ROWS];
  logic [crs_pkg::MASK_W-1:0] shadow_snap [crs_pkg::ROWS];
  int                         printed;

  task automatic report_mismatch(input string msg);
    if (printed < 40) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    printed++;
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  task automatic apply_request(input logic [1:0] kind,
                               input logic [crs_pkg::ROW_W-1:0] row,
                               input logic [crs_pkg::COL_W-1:0] col, input logic close);
    switch_cmd_t                c;
    switch_cmd_t                held;
    logic                       have_held;
    logic [crs_pkg::MASK_W-1:0] col_bit;
    logic [crs_pkg::MASK_W-1:0] diff;
    have_held = 1'b0;
    held = '0;
    case (kind)
      crs_pkg::REQ_SWITCH: begin
        col_bit = crs_pkg::MASK_W'(1) << col;
        c = '{1'b0, row, close ? col_bit : '0, close ? '0 : col_bit, 1'b1};
        if (int'(row) < crs_pkg::ROWS && int'(col) < crs_pkg::COLS) begin
          shadow_live[row] = close ? (shadow_live[row] | col_bit)
                                   : (shadow_live[row] & ~col_bit);
        end
        pending_cmds.push_back(c);
      end
      crs_pkg::REQ_RESET: begin
        for (int r = 0; r < crs_pkg::ROWS; r++) shadow_live[r] = '0;
        pending_cmds.push_back('{1'b1, '0, '0, '0, 1'b1});
      end
      crs_pkg::REQ_SAVE: begin
        for (int r = 0; r < crs_pkg::ROWS; r++) shadow_snap[r] = shadow_live[r];
      end
      crs_pkg::REQ_RESTORE: begin
        for (int r = 0; r < crs_pkg::ROWS; r++) begin
          diff = (shadow_snap[r] ^ shadow_live[r]) & crs_pkg::COL_MASK;
          if (diff != '0) begin
            if (have_held) pending_cmds.push_back(held);
            held = '{1'b0, crs_pkg::ROW_W'(r), shadow_snap[r] & diff,
                     ~shadow_snap[r] & diff, 1'b0};
            have_held = 1'b1;
            shadow_live[r] = shadow_live[r] ^ diff;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          pending_cmds.push_back(held);
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_cmd();
    switch_cmd_t want;
    if (pending_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected command rst %b row %0d on %h off %h last %b",
                                chip_reset, cmd_row, on_mask, off_mask, last));
    end else begin
      want = pending_cmds.pop_front();
      check_field("chip_reset", 8'(chip_reset), 8'(want.chip_reset));
      check_field("cmd_row", 8'(cmd_row), 8'(want.row));
      check_field("on_mask", on_mask, want.on_mask);
      check_field("off_mask", off_mask, want.off_mask);
      check_field("last", 8'(last), 8'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < crs_pkg::ROWS; r++) begin
        shadow_live[r] = '0;
        shadow_snap[r] = '0;
      end
      pending_cmds.delete();
      fail_count = 0;
      printed = 0;
    end else begin
      if (out_valid && !out_stall) take_cmd();
      if (in_valid && !in_stall) apply_request(req_type, sel_row, sel_column, turn_on);
    end
    pending <= pending_cmds.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   req_type = crs_pkg::REQ_SWITCH;
  logic [crs_pkg::ROW_W-1:0]    sel_row = '0;
  logic [crs_pkg::COL_W-1:0]    sel_column = '0;
  logic                         turn_on = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         chip_reset;
  logic [crs_pkg::ROW_W-1:0]    cmd_row;
  logic [crs_pkg::MASK_W-1:0]   on_mask;
  logic [crs_pkg::MASK_W-1:0]   off_mask;
  logic                         last;
  int                           fail_count;
  int                           pending;
  bit                           no_gaps = 1'b0;
  bit                           hold_req = 1'b0;

  crosspoint_shadow_restore_unit dut (
    .clk, .rst, .in_valid, .in_stall, .req_type, .sel_row, .sel_column, .turn_on,
    .out_valid, .out_stall, .chip_reset, .cmd_row, .on_mask, .off_mask, .last
  );

  crosspoint_cmd_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .req_type, .sel_row, .sel_column, .turn_on,
    .out_valid, .out_stall, .chip_reset, .cmd_row, .on_mask, .off_mask, .last,
    .fail_count, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  task automatic offer(input logic [1:0] kind, input logic [crs_pkg::ROW_W-1:0] row,
                       input logic [crs_pkg::COL_W-1:0] col, input logic close);
    int gap;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    sel_row    <= row;
    sel_column <= col;
    turn_on    <= close;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : receiver
    int len;
    bit held_done;
    held_done = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req && !held_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        len = gap_len();
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL crosspoint_shadow_restore_unit");
    $finish;
  end

  initial begin : stimulus
    int pick;
    logic [1:0] kind;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty restore and save, then one channel per row, then a full restore
    offer(crs_pkg::REQ_RESTORE, '0, '0, 1'b0);
    offer(crs_pkg::REQ_SAVE, '1, '1, 1'b1);
    for (int r = 0; r < crs_pkg::ROWS; r++) begin
      offer(crs_pkg::REQ_SWITCH, crs_pkg::ROW_W'(r), crs_pkg::COL_W'(r), 1'b1);
    end
    offer(crs_pkg::REQ_SAVE, '0, '0, 1'b0);
    offer(crs_pkg::REQ_RESET, '0, '0, 1'b0);
    offer(crs_pkg::REQ_RESTORE, '0, '0, 1'b0);
    offer(crs_pkg::REQ_SWITCH, '1, '1, 1'b0);
    offer(crs_pkg::REQ_SWITCH, '0, '0, 1'b0);
    offer(crs_pkg::REQ_RESTORE, '1, '1, 1'b1);

    for (int i = 0; i < 256; i++) begin
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i == 110) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      kind = (pick < 65) ? crs_pkg::REQ_SWITCH :
             (pick < 75) ? crs_pkg::REQ_SAVE :
             (pick < 90) ? crs_pkg::REQ_RESTORE : crs_pkg::REQ_RESET;
      offer(kind, crs_pkg::ROW_W'($urandom), crs_pkg::COL_W'($urandom), 1'($urandom));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS crosspoint_shadow_restore_unit");
    end else begin
      $display("FAIL crosspoint_shadow_restore_unit");
    end
    $finish;
  end

endmodule
